// ===== design/pgm_pkg.sv =====
`timescale 1ns / 1ps

package pgm_pkg;

	// Field widths of the stream words.
	localparam int RANGE_W    = 20;
	localparam int GAP_W      = 7;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// The composite bitmap is stored as 64-bit words.
	localparam int WORD_BITS = 64;
	localparam int WORD_LSB  = 6;

	// Histogram counters saturate at their all-ones value.
	localparam int COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Word 0 after the clearing pass: 0 and 1 are not prime.
	localparam logic [WORD_BITS-1:0] WORD0_INIT = 64'h3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic init_w0;
		logic sv_start;
		logic sv_chk;
		logic sv_next_i;
		logic sv_mark_start;
		logic sv_mark_rd;
		logic sv_mark_wr;
		logic q_load;
		logic w_first;
		logic w_load;
		logic w_bit;
		logic h_wr;
		logic bs_rd;
		logic res_load;
	} pgm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic sq_big;
		logic i_comp;
		logic j_big;
		logic q_empty;
		logic w_zero;
		logic w_last;
		logic pm_zero;
		logic need_hist;
		logic k_last;
	} pgm_sts_t;

endpackage

// ===== design/prime_gap_mode_query.sv =====
// Prime gap champion query over a sieved range of integers.
//
// After reset the block clears its bitmap and histogram memories, then
// runs a sieve of Eratosthenes that marks every composite below LIMIT.
// No query word is taken until the sieve is finished; s_axis_tready
// stays low until then.
// A query word carries range_low and range_high. The block walks the
// primes in that range and counts the gaps between neighboring primes.
// It answers with one word: has_champion and the gap that occurs strictly
// more often than any other, or zero when there is no such gap.
// A query walks each 64-bit bitmap word in the range and each prime
// found, then scans all GAP_BINS bins to pick the winner and clear the
// counts.
// Queries are handled one at a time.
// The result sits in an output register; the next query is taken while
// it waits, and a new result is held back until the previous word leaves.
`timescale 1ns / 1ps

module prime_gap_mode_query #(
	parameter int LIMIT    = 1048576,
	parameter int GAP_BINS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// Bits from lowest: range_low[19:0], range_high[39:20].
	input  logic [pgm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// Bits from lowest: has_champion[0], champion_gap[7:1].
	output logic [pgm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import pgm_pkg::*;

	pgm_cmd_t             cmd;
	pgm_sts_t             sts;
	logic [RANGE_W-1:0]   range_low, range_high;
	logic                 has_champion;
	logic [GAP_W-1:0]     champion_gap;

	// Unpack the query word; the fields stay at the port until accepted.
	assign range_low    = s_axis_tdata[RANGE_W-1:0];
	assign range_high   = s_axis_tdata[2*RANGE_W-1:RANGE_W];
	assign m_axis_tdata = {champion_gap, has_champion};

	// The controller sequences clearing, sieving, the word walk and the
	// final bin scan; it owns the handshakes on both channels.
	pgm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the composite bitmap, the gap histogram and the
	// counters that walk them.
	pgm_dp #(
		.LIMIT    (LIMIT),
		.GAP_BINS (GAP_BINS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.range_low    (range_low),
		.range_high   (range_high),
		.has_champion (has_champion),
		.champion_gap (champion_gap)
	);

endmodule

// ===== design/pgm_dp.sv =====
`timescale 1ns / 1ps

module pgm_dp #(
	parameter int LIMIT    = 1048576,
	parameter int GAP_BINS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pgm_pkg::pgm_cmd_t           cmd,
	output pgm_pkg::pgm_sts_t           sts,
	input  logic [pgm_pkg::RANGE_W-1:0] range_low,
	input  logic [pgm_pkg::RANGE_W-1:0] range_high,
	output logic                        has_champion,
	output logic [pgm_pkg::GAP_W-1:0]   champion_gap
);
	import pgm_pkg::*;

	localparam int NW    = (LIMIT + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
	localparam int AW    = $clog2(LIMIT);
	localparam int PW    = ((AW > RANGE_W) ? AW : RANGE_W) + 1;
	localparam int XW    = PW - WORD_LSB;
	localparam int IW    = (AW + 1) / 2 + 1;
	localparam int BW    = $clog2(GAP_BINS);
	localparam int CLR_N = (NW > GAP_BINS) ? NW : GAP_BINS;
	localparam int CW    = $clog2(CLR_N);

	localparam logic [PW-1:0]       LIM      = PW'(LIMIT);
	localparam logic [PW-1:0]       LIM_M1   = PW'(LIMIT - 1);
	localparam logic [2*IW-1:0]     SQ_LIM   = (2*IW)'(LIMIT);
	localparam logic [PW-1:0]       BINS_P   = PW'(GAP_BINS);
	localparam logic [BW-1:0]       BIN_TOP  = BW'(GAP_BINS - 1);
	localparam logic [CW-1:0]       CLR_LAST = CW'(CLR_N - 1);
	localparam logic [WORD_LSB-1:0] TOP_BIT  = WORD_LSB'(WORD_BITS - 1);

	// Memories.
	logic [WORD_BITS-1:0] map_mem [NW];
	logic [COUNT_W-1:0]   hist_mem [GAP_BINS];

	logic                 map_we, map_re;
	logic [WAW-1:0]       map_wa, map_ra;
	logic [WORD_BITS-1:0] map_wd, map_rd;
	logic                 hist_we, hist_re;
	logic [BW-1:0]        hist_wa, hist_ra;
	logic [COUNT_W-1:0]   hist_wd, hist_rd;

	// Registers.
	logic [CW-1:0]        c_q;
	logic [IW-1:0]        i_q;
	logic [2*IW-1:0]      sq_s1;
	logic [PW-1:0]        j_q;
	logic [PW-1:0]        lo_q, hic_q;
	logic                 empty_q;
	logic [XW-1:0]        w_q;
	logic [WORD_BITS-1:0] pm_q;
	logic [PW-1:0]        prev_q;
	logic                 have_prev_q;
	logic [BW-1:0]        bin_q;
	logic [BW-1:0]        k_q, kb_s1;
	logic                 eval_s1;
	logic [COUNT_W-1:0]   best_q;
	logic [BW-1:0]        bbin_q;
	logic                 uniq_q;
	logic                 has_q;
	logic [GAP_W-1:0]     gap_q;

	// Combinational values.
	logic [PW-1:0]        lo_ext, hi_ext, hic;
	logic [XW-1:0]        lo_w, hi_w;
	logic                 w_last;
	logic [WORD_BITS-1:0] lmask, hmask, masked;
	logic [WORD_LSB-1:0]  lsb, i_bit;
	logic [PW-1:0]        pos, gap;
	logic [BW-1:0]        bin;
	logic                 k_last;

	assign lo_ext = PW'(range_low);
	assign hi_ext = PW'(range_high);
	assign hic    = (hi_ext >= LIM) ? LIM_M1 : hi_ext;

	assign lo_w   = lo_q[PW-1:WORD_LSB];
	assign hi_w   = hic_q[PW-1:WORD_LSB];
	assign w_last = (w_q == hi_w);

	// Keep only candidate bits inside the query range.
	assign lmask  = (w_q == lo_w) ? ({WORD_BITS{1'b1}} << lo_q[WORD_LSB-1:0])
	                              : {WORD_BITS{1'b1}};
	assign hmask  = w_last ? ({WORD_BITS{1'b1}} >> (TOP_BIT - hic_q[WORD_LSB-1:0]))
	                       : {WORD_BITS{1'b1}};
	assign masked = ~map_rd & lmask & hmask;

	// Lowest pending prime in the current word.
	always_comb begin
		lsb = '0;
		for (int n = WORD_BITS - 1; n >= 0; n--) begin
			if (pm_q[n]) begin
				lsb = WORD_LSB'(n);
			end
		end
	end

	assign pos    = {w_q, lsb};
	assign gap    = pos - prev_q;
	assign bin    = (gap >= BINS_P) ? BIN_TOP : BW'(gap);
	assign i_bit  = WORD_LSB'(i_q);
	assign k_last = (k_q == BIN_TOP);

	always_comb begin
		sts.clr_done  = (c_q == CLR_LAST);
		sts.sq_big    = (sq_s1 >= SQ_LIM);
		sts.i_comp    = map_rd[i_bit];
		sts.j_big     = (j_q >= LIM);
		sts.q_empty   = empty_q;
		sts.w_zero    = (masked == '0);
		sts.w_last    = w_last;
		sts.pm_zero   = (pm_q == '0);
		sts.need_hist = (pm_q != '0) && have_prev_q;
		sts.k_last    = k_last;
	end

	// Bitmap port selection.
	always_comb begin
		map_we = 1'b0;
		map_wa = '0;
		map_wd = '0;
		map_re = 1'b0;
		map_ra = '0;
		if (cmd.clr_step && int'(c_q) < NW) begin
			map_we = 1'b1;
			map_wa = WAW'(c_q);
		end
		if (cmd.init_w0) begin
			map_we = 1'b1;
			map_wd = WORD0_INIT;
		end
		if (cmd.sv_mark_wr) begin
			map_we = 1'b1;
			map_wa = WAW'(j_q >> WORD_LSB);
			map_wd = map_rd | (WORD_BITS'(1) << j_q[WORD_LSB-1:0]);
		end
		if (cmd.sv_chk) begin
			map_re = 1'b1;
			map_ra = WAW'(i_q >> WORD_LSB);
		end
		if (cmd.sv_mark_rd) begin
			map_re = 1'b1;
			map_ra = WAW'(j_q >> WORD_LSB);
		end
		if (cmd.w_first) begin
			map_re = 1'b1;
			map_ra = WAW'(lo_w);
		end
		if (cmd.w_load && !w_last) begin
			map_re = 1'b1;
			map_ra = WAW'(w_q + XW'(1));
		end
	end

	// Histogram port selection.
	always_comb begin
		hist_we = 1'b0;
		hist_wa = '0;
		hist_wd = '0;
		hist_re = 1'b0;
		hist_ra = '0;
		if (cmd.clr_step && int'(c_q) < GAP_BINS) begin
			hist_we = 1'b1;
			hist_wa = BW'(c_q);
		end
		if (cmd.h_wr) begin
			hist_we = 1'b1;
			hist_wa = bin_q;
			hist_wd = (hist_rd < COUNT_MAX) ? hist_rd + COUNT_W'(1) : hist_rd;
		end
		if (cmd.bs_rd) begin
			hist_we = 1'b1;
			hist_wa = k_q;
			hist_re = 1'b1;
			hist_ra = k_q;
		end
		if (cmd.w_bit && sts.need_hist) begin
			hist_re = 1'b1;
			hist_ra = bin;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd <= map_mem[map_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		if (hist_re) begin
			hist_rd <= hist_mem[hist_ra];
		end
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q         <= '0;
			have_prev_q <= 1'b0;
			eval_s1     <= 1'b0;
			uniq_q      <= 1'b0;
			best_q      <= '0;
			k_q         <= '0;
		end else begin
			if (cmd.clr_step) begin
				c_q <= c_q + CW'(1);
			end
			eval_s1 <= cmd.bs_rd;
			if (cmd.q_load) begin
				have_prev_q <= 1'b0;
				uniq_q      <= 1'b0;
				best_q      <= '0;
				k_q         <= '0;
			end
			if (cmd.w_bit && pm_q != '0) begin
				have_prev_q <= 1'b1;
			end
			if (cmd.bs_rd) begin
				k_q <= k_last ? '0 : k_q + BW'(1);
			end
			if (eval_s1) begin
				if (hist_rd > best_q) begin
					best_q <= hist_rd;
					uniq_q <= 1'b1;
				end else if (hist_rd == best_q && best_q != '0) begin
					uniq_q <= 1'b0;
				end
			end
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (cmd.sv_start) begin
			i_q <= IW'(2);
		end
		if (cmd.sv_next_i) begin
			i_q <= i_q + IW'(1);
		end
		if (cmd.sv_chk) begin
			sq_s1 <= (2*IW)'(i_q) * (2*IW)'(i_q);
		end
		if (cmd.sv_mark_start) begin
			j_q <= PW'(sq_s1);
		end
		if (cmd.sv_mark_wr) begin
			j_q <= j_q + PW'(i_q);
		end
		if (cmd.q_load) begin
			lo_q    <= lo_ext;
			hic_q   <= hic;
			empty_q <= (lo_ext >= hi_ext) || (lo_ext > hic);
		end
		if (cmd.w_first) begin
			w_q <= lo_w;
		end
		if (cmd.w_load) begin
			pm_q <= masked;
			if (masked == '0 && !w_last) begin
				w_q <= w_q + XW'(1);
			end
		end
		if (cmd.w_bit) begin
			if (pm_q == '0) begin
				if (!w_last) begin
					w_q <= w_q + XW'(1);
				end
			end else begin
				pm_q   <= pm_q & ~(WORD_BITS'(1) << lsb);
				prev_q <= pos;
				bin_q  <= bin;
			end
		end
		if (cmd.bs_rd) begin
			kb_s1 <= k_q;
		end
		if (eval_s1 && hist_rd > best_q) begin
			bbin_q <= kb_s1;
		end
		if (cmd.res_load) begin
			has_q <= uniq_q;
			gap_q <= uniq_q ? GAP_W'(bbin_q) : '0;
		end
	end

	assign has_champion = has_q;
	assign champion_gap = gap_q;

endmodule

// ===== design/pgm_ctrl.sv =====
`timescale 1ns / 1ps

module pgm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pgm_pkg::pgm_cmd_t cmd,
	input  pgm_pkg::pgm_sts_t sts
);
	import pgm_pkg::*;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_INIT  = 4'd1;
	localparam logic [3:0] ST_SCHK  = 4'd2;
	localparam logic [3:0] ST_SCHK2 = 4'd3;
	localparam logic [3:0] ST_MRD   = 4'd4;
	localparam logic [3:0] ST_MWR   = 4'd5;
	localparam logic [3:0] ST_IDLE  = 4'd6;
	localparam logic [3:0] ST_QCHK  = 4'd7;
	localparam logic [3:0] ST_WFST  = 4'd8;
	localparam logic [3:0] ST_WLD   = 4'd9;
	localparam logic [3:0] ST_WBIT  = 4'd10;
	localparam logic [3:0] ST_HWR   = 4'd11;
	localparam logic [3:0] ST_BS    = 4'd12;
	localparam logic [3:0] ST_BE    = 4'd13;
	localparam logic [3:0] ST_RES   = 4'd14;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init_w0  = 1'b1;
				cmd.sv_start = 1'b1;
				state_d      = ST_SCHK;
			end
			ST_SCHK: begin
				cmd.sv_chk = 1'b1;
				state_d    = ST_SCHK2;
			end
			ST_SCHK2: begin
				priority if (sts.sq_big) begin
					state_d = ST_IDLE;
				end else if (sts.i_comp) begin
					cmd.sv_next_i = 1'b1;
					state_d       = ST_SCHK;
				end else begin
					cmd.sv_mark_start = 1'b1;
					state_d           = ST_MRD;
				end
			end
			ST_MRD: begin
				if (sts.j_big) begin
					cmd.sv_next_i = 1'b1;
					state_d       = ST_SCHK;
				end else begin
					cmd.sv_mark_rd = 1'b1;
					state_d        = ST_MWR;
				end
			end
			ST_MWR: begin
				cmd.sv_mark_wr = 1'b1;
				state_d        = ST_MRD;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.q_load = 1'b1;
					state_d    = ST_QCHK;
				end
			end
			ST_QCHK: begin
				state_d = sts.q_empty ? ST_RES : ST_WFST;
			end
			ST_WFST: begin
				cmd.w_first = 1'b1;
				state_d     = ST_WLD;
			end
			ST_WLD: begin
				cmd.w_load = 1'b1;
				if (!sts.w_zero) begin
					state_d = ST_WBIT;
				end else if (sts.w_last) begin
					state_d = ST_BS;
				end
			end
			ST_WBIT: begin
				cmd.w_bit = 1'b1;
				priority if (sts.pm_zero) begin
					state_d = sts.w_last ? ST_BS : ST_WLD;
				end else if (sts.need_hist) begin
					state_d = ST_HWR;
				end
			end
			ST_HWR: begin
				cmd.h_wr = 1'b1;
				state_d  = ST_WBIT;
			end
			ST_BS: begin
				cmd.bs_rd = 1'b1;
				if (sts.k_last) begin
					state_d = ST_BE;
				end
			end
			ST_BE: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_QCHK))
		else $error("accepted query did not start its range check");

	a_hist_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HWR) |-> ($past(state_q) == ST_WBIT && $past(sts.need_hist)))
		else $error("histogram write without a preceding gap");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES && out_valid_q && !out_ready) |=>
		(state_q == ST_RES && out_valid_q))
		else $error("result overwrote a word that was not taken");

	a_ready_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> ($past(state_q) == ST_SCHK2 || $past(state_q) == ST_RES))
		else $error("ready raised outside sieve end or result delivery");

endmodule
